/* design/hnm_pkg.sv */
// Shared types, constants and bit-count helpers for the Hamming nearest-match core.
package hnm_pkg;

    localparam int DESC_W    = 256;
    localparam int WORD_W    = 64;
    localparam int NUM_WORDS = 4;
    localparam int BYTE_W    = 8;
    localparam int LIMIT_W   = 9;
    localparam int QIDX_W    = 16;
    localparam int RIDX_W    = 10;
    localparam int POP_W     = 7;
    localparam int DIST_W    = 9;
    localparam int APB_DW    = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd60;

    // Register index of distance_limit
    localparam logic REG_LIMIT = 1'b0;

    typedef logic [LIMIT_W-1:0] limit_t;
    typedef logic [QIDX_W-1:0]  qidx_t;
    typedef logic [RIDX_W-1:0]  ref_index_t;
    typedef logic [POP_W-1:0]   pop_t;
    typedef logic [DIST_W-1:0]  dist_t;
    typedef logic [3:0]         pop8_t;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_DRAIN  = 2'd2,
        ST_FINISH = 2'd3
    } state_t;

    typedef struct packed {
        logic append_wr;
        logic clear;
        logic query_start;
        logic scan_issue;
        logic result_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic store_empty;
        logic scan_last;
        logic scan_done;
        logic found;
        logic out_busy;
    } dp_status_t;

    function automatic pop8_t pop8(input logic [BYTE_W-1:0] b);
        pop8_t n;
        n = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            n = n + pop8_t'(b[i]);
        end
        return n;
    endfunction

    function automatic pop_t pop64(input logic [WORD_W-1:0] w);
        pop_t n;
        n = '0;
        for (int i = 0; i < WORD_W / BYTE_W; i++)
        begin
            n = n + pop_t'(pop8(w[BYTE_W*i +: BYTE_W]));
        end
        return n;
    endfunction

endpackage

/* design/hamming_nearest_match_core.sv */
// Top level of the Hamming nearest-match core: ports, APB register, controller and datapath.
//
// Brute-force matcher for 256-bit binary descriptors. Each request carries an
// operation and a descriptor: append stores the descriptor as the next
// reference (ignored once REF_DEPTH references are held), clear empties the
// store and zeroes the query counter, query compares the descriptor with every
// stored reference in index order and reports the first reference with the
// lowest Hamming distance, provided it is strictly below distance_limit
// (APB register at byte address 0, reset 60). A matching query yields one
// result (query_index, ref_index); a query without a match yields none but
// still advances the 16-bit query counter. Operation code 3 is accepted and
// ignored. Append, clear and the unused code complete in the idle state. A
// query scans every stored reference (an empty store skips to the finish
// state); the store has a single read port and the scan reads one reference
// per cycle, then a two-stage distance pipeline (per-word bit count, then sum
// and compare) feeds the finish state, which posts the result. The result
// sits in an output register, so the next request is taken while it waits; a
// query that finds a match while the previous result is still untaken holds
// until that result leaves. The reference store has no reset; only written entries are read.
module hamming_nearest_match_core #(
    parameter int REF_DEPTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        operation,
    input  logic [hnm_pkg::WORD_W-1:0]        desc_word0,
    input  logic [hnm_pkg::WORD_W-1:0]        desc_word1,
    input  logic [hnm_pkg::WORD_W-1:0]        desc_word2,
    input  logic [hnm_pkg::WORD_W-1:0]        desc_word3,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [hnm_pkg::QIDX_W-1:0]        query_index,
    output logic [hnm_pkg::RIDX_W-1:0]        ref_index,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [hnm_pkg::APB_DW-1:0]        pwdata,
    output logic [hnm_pkg::APB_DW-1:0]        prdata,
    output logic                              pready
);

    hnm_pkg::ctrl_cmd_t  cmd;
    hnm_pkg::dp_status_t status;
    hnm_pkg::limit_t     limit_reg;
    hnm_pkg::limit_t     limit_next;
    logic                reg_sel;
    logic                wr_en;

    // One register; paddr[2] is the word index, low bits are byte lanes.
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == hnm_pkg::REG_LIMIT);
    assign wr_en   = psel && penable && pwrite && pready && reg_sel;

    assign limit_next = wr_en ? pwdata[hnm_pkg::LIMIT_W-1:0] : limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= hnm_pkg::LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    assign prdata = reg_sel ? hnm_pkg::APB_DW'(limit_reg) : '0;

    // Sequencing of each request
    hnm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .status    (status),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    // Store, distance pipeline and result register
    hnm_datapath #(
        .REF_DEPTH (REF_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .desc_word0  (desc_word0),
        .desc_word1  (desc_word1),
        .desc_word2  (desc_word2),
        .desc_word3  (desc_word3),
        .limit       (limit_reg),
        .out_ready   (out_ready),
        .status      (status),
        .out_valid   (out_valid),
        .query_index (query_index),
        .ref_index   (ref_index)
    );

endmodule

/* design/hnm_ctrl.sv */
// Controller state machine: request decode and query sequencing.
module hnm_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [1:0]             operation,
    input  hnm_pkg::dp_status_t    status,
    output logic                   in_ready,
    output hnm_pkg::ctrl_cmd_t     cmd
);

    hnm_pkg::state_t state_reg;
    hnm_pkg::state_t state_next;
    hnm_pkg::op_t    op;
    logic            accept;

    assign op     = hnm_pkg::op_t'(operation);
    assign accept = in_valid && (state_reg == hnm_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hnm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hnm_pkg::ST_IDLE:
            begin
                if (accept && (op == hnm_pkg::OP_QUERY))
                begin
                    state_next = status.store_empty ? hnm_pkg::ST_FINISH : hnm_pkg::ST_SCAN;
                end
            end
            hnm_pkg::ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = hnm_pkg::ST_DRAIN;
                end
            end
            hnm_pkg::ST_DRAIN:
            begin
                if (status.scan_done)
                begin
                    state_next = hnm_pkg::ST_FINISH;
                end
            end
            hnm_pkg::ST_FINISH:
            begin
                if (!status.found || !status.out_busy)
                begin
                    state_next = hnm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hnm_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready            = 1'b0;
        cmd                 = '0;
        case (state_reg)
            hnm_pkg::ST_IDLE:
            begin
                in_ready        = 1'b1;
                cmd.append_wr   = accept && (op == hnm_pkg::OP_APPEND);
                cmd.clear       = accept && (op == hnm_pkg::OP_CLEAR);
                cmd.query_start = accept && (op == hnm_pkg::OP_QUERY);
            end
            hnm_pkg::ST_SCAN:
            begin
                cmd.scan_issue  = 1'b1;
            end
            hnm_pkg::ST_FINISH:
            begin
                cmd.result_load = status.found && !status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* design/hnm_datapath.sv */
// Datapath: reference store, distance pipeline, best-match tracking, result register.
module hnm_datapath #(
    parameter int REF_DEPTH = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  hnm_pkg::ctrl_cmd_t               cmd,
    input  logic [hnm_pkg::WORD_W-1:0]       desc_word0,
    input  logic [hnm_pkg::WORD_W-1:0]       desc_word1,
    input  logic [hnm_pkg::WORD_W-1:0]       desc_word2,
    input  logic [hnm_pkg::WORD_W-1:0]       desc_word3,
    input  hnm_pkg::limit_t                  limit,
    input  logic                             out_ready,
    output hnm_pkg::dp_status_t              status,
    output logic                             out_valid,
    output logic [hnm_pkg::QIDX_W-1:0]       query_index,
    output logic [hnm_pkg::RIDX_W-1:0]       ref_index
);

    localparam int AW = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
    localparam int CW = $clog2(REF_DEPTH + 1);

    logic [hnm_pkg::DESC_W-1:0] mem [REF_DEPTH];

    logic [hnm_pkg::DESC_W-1:0] desc_in;
    logic [hnm_pkg::DESC_W-1:0] qdesc_reg;
    logic [hnm_pkg::DESC_W-1:0] rdata_reg;
    logic [hnm_pkg::DESC_W-1:0] diff;

    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   scan_addr_reg, scan_addr_next;
    hnm_pkg::qidx_t  qcnt_reg, qcnt_next;
    hnm_pkg::qidx_t  qidx_reg;
    logic            full;

    logic            v1_reg, v2_reg;
    logic            last1_reg, last2_reg;
    logic [AW-1:0]   idx1_reg, idx2_reg;
    hnm_pkg::pop_t   pc_reg [hnm_pkg::NUM_WORDS];

    hnm_pkg::dist_t  cur_dist;
    hnm_pkg::dist_t  best_reg;
    logic [AW-1:0]   best_idx_reg;
    logic            found_reg, found_next;
    logic            upd;

    logic            out_valid_reg, out_valid_next;
    hnm_pkg::qidx_t      out_qidx_reg;
    hnm_pkg::ref_index_t out_ridx_reg;

    assign desc_in = {desc_word3, desc_word2, desc_word1, desc_word0};
    assign full    = (count_reg == CW'(REF_DEPTH));
    assign diff    = rdata_reg ^ qdesc_reg;

    assign cur_dist = hnm_pkg::dist_t'(pc_reg[0]) + hnm_pkg::dist_t'(pc_reg[1])
                    + hnm_pkg::dist_t'(pc_reg[2]) + hnm_pkg::dist_t'(pc_reg[3]);
    assign upd  = v2_reg && (cur_dist < best_reg);

    // Next values of control state
    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.append_wr && !full)
        begin
            count_next = count_reg + CW'(1);
        end

        qcnt_next = qcnt_reg;
        if (cmd.clear)
        begin
            qcnt_next = '0;
        end
        else if (cmd.query_start)
        begin
            qcnt_next = qcnt_reg + hnm_pkg::qidx_t'(1);
        end

        scan_addr_next = scan_addr_reg;
        if (cmd.query_start)
        begin
            scan_addr_next = '0;
        end
        else if (cmd.scan_issue)
        begin
            scan_addr_next = scan_addr_reg + AW'(1);
        end

        found_next = found_reg;
        if (cmd.query_start)
        begin
            found_next = 1'b0;
        end
        else if (upd)
        begin
            found_next = 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (cmd.result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            qcnt_reg      <= '0;
            scan_addr_reg <= '0;
            found_reg     <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            qcnt_reg      <= qcnt_next;
            scan_addr_reg <= scan_addr_next;
            found_reg     <= found_next;
            v1_reg        <= cmd.scan_issue;
            v2_reg        <= v1_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    // Reference store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.append_wr && !full)
        begin
            mem[count_reg[AW-1:0]] <= desc_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_issue)
        begin
            rdata_reg <= mem[scan_addr_reg];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.query_start)
        begin
            qdesc_reg <= desc_in;
            qidx_reg  <= qcnt_reg;
            best_reg  <= limit;
        end
        else if (upd)
        begin
            best_reg  <= cur_dist;
        end

        if (upd)
        begin
            best_idx_reg <= idx2_reg;
        end

        if (cmd.scan_issue)
        begin
            idx1_reg  <= scan_addr_reg;
            last1_reg <= status.scan_last;
        end

        if (v1_reg)
        begin
            idx2_reg  <= idx1_reg;
            last2_reg <= last1_reg;
            for (int k = 0; k < hnm_pkg::NUM_WORDS; k++)
            begin
                pc_reg[k] <= hnm_pkg::pop64(diff[hnm_pkg::WORD_W*k +: hnm_pkg::WORD_W]);
            end
        end

        if (cmd.result_load)
        begin
            out_qidx_reg <= qidx_reg;
            out_ridx_reg <= hnm_pkg::ref_index_t'(best_idx_reg);
        end
    end

    always_comb
    begin
        status.store_empty = (count_reg == '0);
        status.scan_last   = (CW'(scan_addr_reg) == (count_reg - CW'(1)));
        status.scan_done   = v2_reg && last2_reg;
        status.found       = found_reg;
        status.out_busy    = out_valid_reg && !out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign query_index = out_qidx_reg;
    assign ref_index   = out_ridx_reg;

endmodule

/* design/hnm_checker.sv */
// Port-level assertions for the Hamming nearest-match core, bound to the top level.
module hnm_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic [1:0]                   operation,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [hnm_pkg::QIDX_W-1:0]   query_index,
    input logic [hnm_pkg::RIDX_W-1:0]   ref_index
);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(query_index) && $stable(ref_index))
        else $error("result changed while stalled");

    // A query keeps the request side busy for at least the next cycle
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (operation == hnm_pkg::OP_QUERY) |=> !in_ready)
        else $error("request taken right after a query");

    // Append, clear and the unused code leave the request side ready in the next cycle
    a_short_ops: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (operation != hnm_pkg::OP_QUERY) |=> in_ready)
        else $error("non-query request stalled the request side");

    // A new result appears only at the end of a query, never from idle
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result posted while idle");

endmodule

bind hamming_nearest_match_core hnm_checker u_hnm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .query_index (query_index),
    .ref_index   (ref_index)
);

/* bench/hamming_nearest_match_core_tb.sv */
// Testbench for hamming_nearest_match_core: directed table, pressure, random traffic.
module hamming_nearest_match_core_tb;
    import hnm_pkg::*;

    localparam int REF_DEPTH      = 1024;
    localparam int IDLE_PCT       = 23;
    localparam int RANDOM_ITEMS   = 530;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int MAX_REPORTS    = 10;
    // scan pipeline tail beyond one cycle per stored reference
    localparam int SCAN_TAIL      = 8;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [2:0] LIMIT_ADDR = 3'(4 * REG_LIMIT);

    // descriptor patterns for the directed table
    localparam logic [DESC_W-1:0] ALL0  = '0;
    localparam logic [DESC_W-1:0] ALL1  = '1;
    localparam logic [DESC_W-1:0] LOW1  = 256'h1;
    localparam logic [DESC_W-1:0] LOW3  = 256'h7;
    localparam logic [DESC_W-1:0] ALT   = {64{4'h5}};
    localparam logic [DESC_W-1:0] PAT_A = {64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                                           64'h0F1E_2D3C_4B5A_6978, 64'h8796_A5B4_C3D2_E1F0};
    localparam logic [DESC_W-1:0] MSB   = 256'h1 << (DESC_W - 1);

    typedef struct packed {
        qidx_t      qi;
        ref_index_t ri;
    } match_t;

    typedef enum logic {
        ROW_REQ,
        ROW_LIMIT
    } row_kind_t;

    // how a request's result is checked
    typedef enum logic [1:0] {
        CHK_MODEL,   // whatever the predictor says
        CHK_NONE,    // no result, typed in
        CHK_MATCH    // typed-in match
    } check_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        limit_t            limit;
        logic [1:0]        op;
        logic [DESC_W-1:0] desc;
        check_kind_t       how;
        match_t            want;
    } dir_row_t;

    localparam int NUM_DIRECTED = 25;

    // Directed table. Starts right after reset: limit 60, empty store, query counter 0.
    localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
        '{ROW_REQ,   9'd0,   OP_QUERY,  ALL0,          CHK_NONE,  '0},            // empty store
        '{ROW_REQ,   9'd0,   OP_UNUSED, ALL1,          CHK_NONE,  '0},            // unused code
        '{ROW_REQ,   9'd0,   OP_APPEND, ALL0,          CHK_NONE,  '0},            // ref 0
        '{ROW_REQ,   9'd0,   OP_APPEND, ALL1,          CHK_NONE,  '0},            // ref 1
        '{ROW_REQ,   9'd0,   OP_QUERY,  ALL0,          CHK_MATCH, '{16'd1, 10'd0}},
        '{ROW_REQ,   9'd0,   OP_QUERY,  ALL1,          CHK_MATCH, '{16'd2, 10'd1}},
        '{ROW_REQ,   9'd0,   OP_APPEND, LOW3,          CHK_NONE,  '0},            // ref 2
        '{ROW_REQ,   9'd0,   OP_APPEND, ALL0,          CHK_NONE,  '0},            // ref 3 = ref 0
        '{ROW_REQ,   9'd0,   OP_QUERY,  LOW1,          CHK_MATCH, '{16'd3, 10'd0}},   // tie
        '{ROW_REQ,   9'd0,   OP_QUERY,  ALT,           CHK_NONE,  '0},            // all >= 60
        '{ROW_LIMIT, 9'd257, 2'd0,      ALL0,          CHK_MODEL, '0},
        '{ROW_REQ,   9'd0,   OP_QUERY,  ALT,           CHK_MODEL, '0},            // anything goes
        '{ROW_LIMIT, 9'd0,   2'd0,      ALL0,          CHK_MODEL, '0},
        '{ROW_REQ,   9'd0,   OP_QUERY,  ALL0,          CHK_NONE,  '0},            // limit 0
        '{ROW_REQ,   9'd0,   OP_CLEAR,  ALL1,          CHK_NONE,  '0},
        '{ROW_REQ,   9'd0,   OP_APPEND, PAT_A,         CHK_NONE,  '0},
        '{ROW_LIMIT, 9'd256, 2'd0,      ALL0,          CHK_MODEL, '0},
        '{ROW_REQ,   9'd0,   OP_QUERY,  ~PAT_A,        CHK_NONE,  '0},            // 256 not < 256
        '{ROW_LIMIT, 9'd257, 2'd0,      ALL0,          CHK_MODEL, '0},
        '{ROW_REQ,   9'd0,   OP_QUERY,  ~PAT_A,        CHK_MATCH, '{16'd1, 10'd0}},
        '{ROW_LIMIT, 9'd1,   2'd0,      ALL0,          CHK_MODEL, '0},
        '{ROW_REQ,   9'd0,   OP_QUERY,  PAT_A,         CHK_MATCH, '{16'd2, 10'd0}},
        '{ROW_REQ,   9'd0,   OP_QUERY,  PAT_A ^ LOW1,  CHK_NONE,  '0},            // 1 not < 1
        '{ROW_LIMIT, 9'd60,  2'd0,      ALL0,          CHK_MODEL, '0},
        '{ROW_REQ,   9'd0,   OP_QUERY,  PAT_A ^ MSB,   CHK_MODEL, '0}
    };

    // DUT inputs, all known from time zero
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic [1:0]         operation = '0;
    logic [WORD_W-1:0]  desc_word0 = '0;
    logic [WORD_W-1:0]  desc_word1 = '0;
    logic [WORD_W-1:0]  desc_word2 = '0;
    logic [WORD_W-1:0]  desc_word3 = '0;
    logic               out_ready = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [2:0]         paddr     = '0;
    logic [APB_DW-1:0]  pwdata    = '0;

    logic               in_ready;
    logic               out_valid;
    qidx_t              query_index;
    ref_index_t         ref_index;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    // Shadow of the block's state, kept by the predictor.
    logic [DESC_W-1:0]  ref_store [$];
    qidx_t              query_count = '0;
    limit_t             limit_reg   = LIMIT_RESET;

    // Matches still owed by the block, oldest first.
    match_t             pending_matches [$];

    int                 mismatches   = 0;
    int                 stall_cycles = 0;
    bit                 no_idle      = 1'b0;   // shared by both sides: a stretch with no gaps
    bit                 hold_off_req = 1'b0;   // asks the result side for a long stall

    hamming_nearest_match_core #(
        .REF_DEPTH (REF_DEPTH)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .desc_word0  (desc_word0),
        .desc_word1  (desc_word1),
        .desc_word2  (desc_word2),
        .desc_word3  (desc_word3),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .query_index (query_index),
        .ref_index   (ref_index),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Nearest-match prediction for one accepted request. Returns 1 with the match
    // when a query finds a stored reference strictly below the limit.
    function automatic bit predict_request(input logic [1:0] op, input logic [DESC_W-1:0] d,
                                           output match_t m);
        int best;
        int hd;
        bit found;

        found = 1'b0;
        m     = '0;
        case (op)
            OP_APPEND:
            begin
                // a full store drops the append
                if (ref_store.size() < REF_DEPTH)
                    ref_store = {ref_store, d};
            end
            OP_CLEAR:
            begin
                ref_store.delete();
                query_count = '0;
            end
            OP_QUERY:
            begin
                m.qi        = query_count;
                query_count = query_count + 1'b1;   // wraps at 16 bits
                best        = int'(limit_reg);
                foreach (ref_store[j])
                begin
                    hd = $countones(d ^ ref_store[j]);
                    // strict compare: on a tie the lower index stays
                    if (hd < best)
                    begin
                        best  = hd;
                        m.ri  = ref_index_t'(j);
                        found = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return found;
    endfunction

    function automatic logic [DESC_W-1:0] rand_desc();
        return {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic logic [DESC_W-1:0] flip_bits(input logic [DESC_W-1:0] d,
                                                    input int unsigned n);
        logic [DESC_W-1:0] r;

        r = d;
        repeat (n)
            r[$urandom_range(DESC_W - 1)] ^= 1'b1;
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // One request through the valid/ready handshake. Valid stays high on return,
    // so back-to-back requests never drop it; a gap or drain lowers it.
    task automatic send_req(input logic [1:0] op, input logic [DESC_W-1:0] d,
                            input check_kind_t how = CHK_MODEL, input match_t want = '0);
        match_t m;
        bit     hit;

        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        desc_word0 <= d[63:0];
        desc_word1 <= d[127:64];
        desc_word2 <= d[191:128];
        desc_word3 <= d[255:192];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // accepted at this edge
        hit = predict_request(op, d, m);
        case (how)
            CHK_MODEL:
            begin
                if (hit)
                    pending_matches = {pending_matches, m};
            end
            CHK_MATCH:
                pending_matches = {pending_matches, want};
            default:
            begin
            end
        endcase
    endtask

    // Stop offering, wait for every owed match, then let a full scan of the
    // current store run out in case the last query ends without a result.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (ref_store.size() + SCAN_TAIL)
            @(posedge clk);
    endtask

    // Limit register write, then read back over APB. Only called with the block idle.
    task automatic write_limit(input limit_t v);
        logic [APB_DW-1:0] readback;

        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= APB_DW'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        limit_reg = v;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== APB_DW'(v))
            flag_mismatch($sformatf("distance_limit readback exp %0d got %0d", v, readback));
    endtask

    task automatic run_directed();
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            if (DIRECTED[i].kind == ROW_LIMIT)
                write_limit(DIRECTED[i].limit);
            else
                send_req(DIRECTED[i].op, DIRECTED[i].desc, DIRECTED[i].how, DIRECTED[i].want);
        end
    endtask

    // Every query here matches, so with the result side held off the output
    // register fills, the next matching query parks and requests back up.
    task automatic run_backpressure();
        send_req(OP_CLEAR, rand_desc());
        repeat (4)
            send_req(OP_APPEND, rand_desc());
        hold_off_req = 1'b1;
        repeat (12)
            send_req(OP_QUERY, ref_store[$urandom_range(3)]);
        drain();
    endtask

    // Mostly well-formed episodes: optional clear, a handful of appends (some
    // duplicates, for ties), then queries near stored references so the limit
    // actually decides. The rest is noise, including the unused code.
    task automatic run_random_traffic();
        int unsigned       sent;
        int unsigned       pick;
        logic [1:0]        op;
        logic [DESC_W-1:0] d;

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            no_idle = (sent >= 200 && sent < 330);
            if ($urandom_range(99) < 10)
            begin
                case ($urandom_range(5))
                    0:       write_limit(limit_t'(0));
                    1:       write_limit(limit_t'(257));
                    2:       write_limit(limit_t'(256));
                    3:       write_limit(LIMIT_RESET);
                    default: write_limit(limit_t'($urandom_range(1, 256)));
                endcase
            end
            if ($urandom_range(99) < 15)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    op = 2'($urandom_range(3));
                    send_req(op, rand_desc());
                    if (op != OP_UNUSED)
                        sent++;
                end
            end
            else
            begin
                if (ref_store.size() > 48 || $urandom_range(1) == 0)
                begin
                    send_req(OP_CLEAR, rand_desc());
                    sent++;
                end
                repeat ($urandom_range(1, 16))
                begin
                    if (ref_store.size() != 0 && $urandom_range(9) == 0)
                        d = ref_store[$urandom_range(ref_store.size() - 1)];
                    else
                        d = rand_desc();
                    send_req(OP_APPEND, d);
                    sent++;
                end
                repeat ($urandom_range(1, 10))
                begin
                    pick = $urandom_range(ref_store.size() - 1);
                    case ($urandom_range(9))
                        0, 1:    d = rand_desc();
                        2:       d = ref_store[pick];
                        default: d = flip_bits(ref_store[pick], $urandom_range(0, 70));
                    endcase
                    send_req(OP_QUERY, d);
                    sent++;
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // Result side: random stalls, a long hold-off on request, none during the
    // no-idle stretch.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                hold_off_req = 1'b0;
            end
            out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Result checking and watchdog. Sampling right after the edge sees the
    // values the handshake was decided on.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_matches.size() == 0)
                flag_mismatch($sformatf("unexpected result query_index=%0d ref_index=%0d",
                                        query_index, ref_index));
            else if (query_index !== pending_matches[0].qi ||
                     ref_index !== pending_matches[0].ri)
                flag_mismatch($sformatf("query_index exp %0d got %0d, ref_index exp %0d got %0d",
                                        pending_matches[0].qi, query_index,
                                        pending_matches[0].ri, ref_index));
            if (pending_matches.size() != 0)
                void'(pending_matches.pop_front());
        end
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_backpressure();
        run_random_traffic();
        drain();

        if (mismatches == 0 && pending_matches.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* files.f */
design/hnm_pkg.sv
design/hnm_ctrl.sv
design/hnm_datapath.sv
design/hamming_nearest_match_core.sv
design/hnm_checker.sv
bench/hamming_nearest_match_core_tb.sv
